/* sv/cjc_pkg.sv */
// Shared types, constants and codes for the join configuration parser.
// Used by cjc_front, cjc_back and cbor_join_config_parser_core.
`timescale 1ns / 1ps
`default_nettype none

package cjc_pkg;

  // Sizing of the object that is accepted.
  localparam int MaxKeys        = 4;
  localparam int MaxParams      = 3;
  localparam int MinKeyElements = 2;
  localparam int KcW            = $clog2(MaxKeys + 1);
  localparam int KIdxW          = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;

  // CBOR major types and header values.
  localparam logic [2:0] MajorUint  = 3'd0;
  localparam logic [2:0] MajorBstr  = 3'd2;
  localparam logic [2:0] MajorArray = 3'd4;
  localparam logic [2:0] MajorMap   = 3'd5;
  localparam logic [4:0] AiMaxImm   = 5'd23;
  localparam logic [4:0] AiOneByte  = 5'd24;
  localparam logic [4:0] AiMaxLease = 5'd27;
  localparam logic [4:0] AiKeyLen   = 5'd16;
  localparam logic [4:0] KeyLen     = 5'd16;
  localparam logic [4:0] SaLen      = 5'd2;
  localparam logic [7:0] HdrSaBstr  = 8'h42;
  localparam logic [7:0] HdrCaBstr  = 8'h50;

  // Result kinds.
  localparam logic [1:0] KindKey    = 2'd0;
  localparam logic [1:0] KindShort  = 2'd1;
  localparam logic [1:0] KindCtrl   = 2'd2;
  localparam logic [1:0] KindStatus = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegLabelKs     = 2'd0;
  localparam logic [1:0] RegLabelSa     = 2'd1;
  localparam logic [1:0] RegLabelCa     = 2'd2;
  localparam logic [1:0] RegDefaultUse  = 2'd3;

  typedef enum logic [3:0] {
    PhMap, PhLabel, PhKsArr, PhKsIdx, PhKsIdxX, PhKsAfterIdx, PhKsUseX, PhKsBstr,
    PhKsBytes, PhSaArr, PhSaBstr, PhSaBytes, PhSaLease, PhCaHdr, PhCaBytes, PhEnd
  } phase_e;

  typedef enum logic [2:0] {
    BParse, BKeyRead, BKeyOut, BShort, BCtrl, BStatus
  } burst_e;

  // One classified byte in the queue between front and back.
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] major;
    logic [4:0] ai;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [4:0] label_ks;
    logic [4:0] label_sa;
    logic [4:0] label_ca;
    logic [7:0] default_use;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/cjc_front.sv */
// Front end: takes bytes, splits the CBOR header fields and queues them.
// Depends on cjc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cjc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          last_byte_i,
  output logic               item_valid_o,
  output cjc_pkg::item_t     item_o,
  input  wire logic          item_pop_i
);

  cjc_pkg::item_t q_mem [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           wr_en, rd_en;
  cjc_pkg::item_t item_in;

  // Classify the incoming byte.
  always_comb begin
    item_in.data  = data_byte_i;
    item_in.major = data_byte_i[7:5];
    item_in.ai    = data_byte_i[4:0];
    item_in.last  = last_byte_i;
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_pop_i && item_valid_o;
  assign item_o       = q_mem[rptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wptr_q] <= item_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_en) wptr_q <= !wptr_q;
      if (rd_en) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

`default_nettype wire

/* sv/cjc_back.sv */
// Back end: runs the map parser on queued bytes and plays out the result burst.
// Depends on cjc_pkg; holds the key store and the output register.
`timescale 1ns / 1ps
`default_nettype none

module cjc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cjc_pkg::cfg_t      cfg_i,
  input  wire logic          item_valid_i,
  input  cjc_pkg::item_t     item_i,
  output logic               item_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         key_id_o,
  output logic [7:0]         key_use_o,
  output logic [63:0]        word_high_o,
  output logic [63:0]        word_low_o,
  output logic               status_o,
  output logic               last_o
);

  localparam int EntryW = 8 + 8 + 128;

  cjc_pkg::phase_e phase_q, phase_d;
  cjc_pkg::burst_e burst_q, burst_d;
  logic [4:0]  ent_q, ent_d, el_q, el_d, sbl_q, sbl_d;
  logic [cjc_pkg::KcW-1:0] kc_q, kc_d, ek_q, ek_d;
  logic        err_q, err_d, fail_q, fail_d;
  logic [1:0]  pres_q, pres_d;
  logic [7:0]  cur_idx_q, cur_idx_d, cur_use_q, cur_use_d;
  logic [119:0] cur_key_q, cur_key_d;
  logic [127:0] ca_q, ca_d;
  logic [15:0] sa_q, sa_d;

  logic [EntryW-1:0] key_mem [cjc_pkg::MaxKeys];
  logic [EntryW-1:0] key_rd_q;
  logic              mem_wr, mem_rd;

  logic        out_valid_q, out_free, load;
  logic [1:0]  o_kind_q, o_kind_d;
  logic [7:0]  o_idx_q, o_idx_d, o_use_q, o_use_d;
  logic [63:0] o_hi_q, o_hi_d, o_lo_q, o_lo_d;
  logic        o_st_q, o_st_d, o_last_q, o_last_d;

  logic [7:0] b;
  logic [2:0] major;
  logic [4:0] ai;
  logic [4:0] sbl_dec;

  assign b        = item_i.data;
  assign major    = item_i.major;
  assign ai       = item_i.ai;
  assign sbl_dec  = sbl_q - 5'd1;
  assign out_free = !out_valid_q || pop_i;

  // Parser and burst sequencer.
  always_comb begin
    phase_d   = phase_q;
    burst_d   = burst_q;
    ent_d     = ent_q;
    el_d      = el_q;
    sbl_d     = sbl_q;
    kc_d      = kc_q;
    ek_d      = ek_q;
    err_d     = err_q;
    fail_d    = fail_q;
    pres_d    = pres_q;
    cur_idx_d = cur_idx_q;
    cur_use_d = cur_use_q;
    cur_key_d = cur_key_q;
    ca_d      = ca_q;
    sa_d      = sa_q;
    mem_wr    = 1'b0;
    mem_rd    = 1'b0;
    load      = 1'b0;
    o_kind_d  = cjc_pkg::KindStatus;
    o_idx_d   = 8'd0;
    o_use_d   = 8'd0;
    o_hi_d    = 64'd0;
    o_lo_d    = 64'd0;
    o_st_d    = 1'b0;
    o_last_d  = 1'b0;
    item_pop_o = (burst_q == cjc_pkg::BParse);

    unique case (burst_q)
      cjc_pkg::BParse: begin
        if (item_valid_i) begin
          if (!err_q) begin
            unique case (phase_q)
              cjc_pkg::PhMap: begin
                if (major != cjc_pkg::MajorMap || ai > 5'(cjc_pkg::MaxParams)) begin
                  err_d = 1'b1;
                end else begin
                  ent_d   = ai;
                  phase_d = (ai == 5'd0) ? cjc_pkg::PhEnd : cjc_pkg::PhLabel;
                end
              end
              cjc_pkg::PhLabel: begin
                if (b == {3'd0, cfg_i.label_ks}) phase_d = cjc_pkg::PhKsArr;
                else if (b == {3'd0, cfg_i.label_sa}) phase_d = cjc_pkg::PhSaArr;
                else if (b == {3'd0, cfg_i.label_ca}) phase_d = cjc_pkg::PhCaHdr;
                else err_d = 1'b1;
              end
              cjc_pkg::PhKsArr: begin
                if (major != cjc_pkg::MajorArray || ai < 5'(cjc_pkg::MinKeyElements) ||
                    ai > cjc_pkg::AiMaxImm) begin
                  err_d = 1'b1;
                end else begin
                  el_d    = ai;
                  kc_d    = '0;
                  phase_d = cjc_pkg::PhKsIdx;
                end
              end
              cjc_pkg::PhKsIdx: begin
                if (kc_q >= cjc_pkg::KcW'(cjc_pkg::MaxKeys) || el_q == 5'd0 ||
                    major != cjc_pkg::MajorUint || ai > cjc_pkg::AiOneByte) begin
                  err_d = 1'b1;
                end else begin
                  el_d      = el_q - 5'd1;
                  cur_idx_d = {3'd0, ai};
                  cur_use_d = cfg_i.default_use;
                  phase_d   = (ai == cjc_pkg::AiOneByte) ? cjc_pkg::PhKsIdxX
                                                         : cjc_pkg::PhKsAfterIdx;
                end
              end
              cjc_pkg::PhKsIdxX: begin
                cur_idx_d = b;
                phase_d   = cjc_pkg::PhKsAfterIdx;
              end
              cjc_pkg::PhKsAfterIdx: begin
                if (el_q != 5'd0 && major == cjc_pkg::MajorUint &&
                    ai <= cjc_pkg::AiOneByte) begin
                  el_d = el_q - 5'd1;
                  if (ai == cjc_pkg::AiOneByte) begin
                    phase_d = cjc_pkg::PhKsUseX;
                  end else begin
                    cur_use_d = {3'd0, ai};
                    phase_d   = cjc_pkg::PhKsBstr;
                  end
                end else if (el_q == 5'd0 || major != cjc_pkg::MajorBstr ||
                             ai != cjc_pkg::AiKeyLen) begin
                  err_d = 1'b1;
                end else begin
                  el_d    = el_q - 5'd1;
                  sbl_d   = cjc_pkg::KeyLen;
                  phase_d = cjc_pkg::PhKsBytes;
                end
              end
              cjc_pkg::PhKsUseX: begin
                cur_use_d = b;
                phase_d   = cjc_pkg::PhKsBstr;
              end
              cjc_pkg::PhKsBstr: begin
                if (el_q == 5'd0 || major != cjc_pkg::MajorBstr ||
                    ai != cjc_pkg::AiKeyLen) begin
                  err_d = 1'b1;
                end else begin
                  el_d    = el_q - 5'd1;
                  sbl_d   = cjc_pkg::KeyLen;
                  phase_d = cjc_pkg::PhKsBytes;
                end
              end
              cjc_pkg::PhKsBytes: begin
                cur_key_d = {cur_key_q[111:0], b};
                sbl_d     = sbl_dec;
                if (sbl_dec == 5'd0) begin
                  mem_wr = 1'b1;
                  kc_d   = kc_q + 1'b1;
                  if (el_q == 5'd0) begin
                    ent_d   = ent_q - 5'd1;
                    phase_d = (ent_q == 5'd1) ? cjc_pkg::PhEnd : cjc_pkg::PhLabel;
                  end else begin
                    phase_d = cjc_pkg::PhKsIdx;
                  end
                end
              end
              cjc_pkg::PhSaArr: begin
                if (major != cjc_pkg::MajorArray || ai < 5'd1 || ai > 5'd2) begin
                  err_d = 1'b1;
                end else begin
                  el_d    = ai;
                  phase_d = cjc_pkg::PhSaBstr;
                end
              end
              cjc_pkg::PhSaBstr: begin
                if (b != cjc_pkg::HdrSaBstr) begin
                  err_d = 1'b1;
                end else begin
                  sbl_d   = cjc_pkg::SaLen;
                  phase_d = cjc_pkg::PhSaBytes;
                end
              end
              cjc_pkg::PhSaBytes: begin
                if (el_q != 5'd0) sa_d = {sa_q[7:0], b};
                sbl_d = sbl_dec;
                if (sbl_dec == 5'd0) begin
                  if (el_q == 5'd2) begin
                    pres_d[0] = 1'b1;
                    el_d      = 5'd1;
                    phase_d   = cjc_pkg::PhSaLease;
                  end else begin
                    if (el_q == 5'd1) pres_d[0] = 1'b1;
                    el_d    = 5'd0;
                    ent_d   = ent_q - 5'd1;
                    phase_d = (ent_q == 5'd1) ? cjc_pkg::PhEnd : cjc_pkg::PhLabel;
                  end
                end
              end
              cjc_pkg::PhSaLease: begin
                if (major != cjc_pkg::MajorUint || ai > cjc_pkg::AiMaxLease) begin
                  err_d = 1'b1;
                end else begin
                  el_d = 5'd0;
                  if (ai < cjc_pkg::AiOneByte) begin
                    ent_d   = ent_q - 5'd1;
                    phase_d = (ent_q == 5'd1) ? cjc_pkg::PhEnd : cjc_pkg::PhLabel;
                  end else begin
                    sbl_d   = 5'd1 << (ai[1:0]);
                    phase_d = cjc_pkg::PhSaBytes;
                  end
                end
              end
              cjc_pkg::PhCaHdr: begin
                if (b != cjc_pkg::HdrCaBstr) begin
                  err_d = 1'b1;
                end else begin
                  sbl_d   = cjc_pkg::KeyLen;
                  phase_d = cjc_pkg::PhCaBytes;
                end
              end
              cjc_pkg::PhCaBytes: begin
                ca_d  = {ca_q[119:0], b};
                sbl_d = sbl_dec;
                if (sbl_dec == 5'd0) begin
                  pres_d[1] = 1'b1;
                  ent_d     = ent_q - 5'd1;
                  phase_d   = (ent_q == 5'd1) ? cjc_pkg::PhEnd : cjc_pkg::PhLabel;
                end
              end
              cjc_pkg::PhEnd: err_d = 1'b1;
              default: err_d = 1'b1;
            endcase
          end
          if (item_i.last) begin
            burst_d = cjc_pkg::BKeyRead;
            ek_d    = '0;
          end
        end
      end
      cjc_pkg::BKeyRead: begin
        if (err_q || phase_q != cjc_pkg::PhEnd) begin
          fail_d  = 1'b1;
          burst_d = cjc_pkg::BStatus;
        end else if (ek_q < kc_q) begin
          mem_rd  = 1'b1;
          burst_d = cjc_pkg::BKeyOut;
        end else begin
          burst_d = cjc_pkg::BShort;
        end
      end
      cjc_pkg::BKeyOut: begin
        if (out_free) begin
          load     = 1'b1;
          o_kind_d = cjc_pkg::KindKey;
          {o_idx_d, o_use_d, o_hi_d, o_lo_d} = key_rd_q;
          ek_d     = ek_q + 1'b1;
          burst_d  = cjc_pkg::BKeyRead;
        end
      end
      cjc_pkg::BShort: begin
        if (!pres_q[0]) begin
          burst_d = cjc_pkg::BCtrl;
        end else if (out_free) begin
          load     = 1'b1;
          o_kind_d = cjc_pkg::KindShort;
          o_lo_d   = {48'd0, sa_q};
          burst_d  = cjc_pkg::BCtrl;
        end
      end
      cjc_pkg::BCtrl: begin
        if (!pres_q[1]) begin
          burst_d = cjc_pkg::BStatus;
        end else if (out_free) begin
          load     = 1'b1;
          o_kind_d = cjc_pkg::KindCtrl;
          o_hi_d   = ca_q[127:64];
          o_lo_d   = ca_q[63:0];
          burst_d  = cjc_pkg::BStatus;
        end
      end
      cjc_pkg::BStatus: begin
        if (out_free) begin
          load     = 1'b1;
          o_kind_d = cjc_pkg::KindStatus;
          o_st_d   = fail_q;
          o_last_d = 1'b1;
          // Start a fresh object.
          fail_d   = 1'b0;
          phase_d  = cjc_pkg::PhMap;
          ent_d    = 5'd0;
          el_d     = 5'd0;
          sbl_d    = 5'd0;
          kc_d     = '0;
          err_d    = 1'b0;
          pres_d   = 2'd0;
          sa_d     = 16'd0;
          ca_d     = 128'd0;
          burst_d  = cjc_pkg::BParse;
        end
      end
      default: burst_d = cjc_pkg::BParse;
    endcase
  end

  // Key store: one write port from the parser, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      key_mem[kc_q[cjc_pkg::KIdxW-1:0]] <= {cur_idx_q, cur_use_q, cur_key_q, b};
    end
    if (mem_rd) begin
      key_rd_q <= key_mem[ek_q[cjc_pkg::KIdxW-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cjc_pkg::PhMap;
      burst_q     <= cjc_pkg::BParse;
      ent_q       <= 5'd0;
      el_q        <= 5'd0;
      sbl_q       <= 5'd0;
      kc_q        <= '0;
      ek_q        <= '0;
      err_q       <= 1'b0;
      fail_q      <= 1'b0;
      pres_q      <= 2'd0;
      sa_q        <= 16'd0;
      ca_q        <= 128'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      burst_q     <= burst_d;
      ent_q       <= ent_d;
      el_q        <= el_d;
      sbl_q       <= sbl_d;
      kc_q        <= kc_d;
      ek_q        <= ek_d;
      err_q       <= err_d;
      fail_q      <= fail_d;
      pres_q      <= pres_d;
      sa_q        <= sa_d;
      ca_q        <= ca_d;
      out_valid_q <= load || (out_valid_q && !pop_i);
    end
  end

  // Payload registers of the current key group and of the result.
  always_ff @(posedge clk_i) begin
    cur_idx_q <= cur_idx_d;
    cur_use_q <= cur_use_d;
    cur_key_q <= cur_key_d;
    if (load) begin
      o_kind_q <= o_kind_d;
      o_idx_q  <= o_idx_d;
      o_use_q  <= o_use_d;
      o_hi_q   <= o_hi_d;
      o_lo_q   <= o_lo_d;
      o_st_q   <= o_st_d;
      o_last_q <= o_last_d;
    end
  end

  assign empty_o     = !out_valid_q;
  assign kind_o      = o_kind_q;
  assign key_id_o    = o_idx_q;
  assign key_use_o   = o_use_q;
  assign word_high_o = o_hi_q;
  assign word_low_o  = o_lo_q;
  assign status_o    = o_st_q;
  assign last_o      = o_last_q;

  // The key count never passes the size of the key store.
  a_kc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kc_q <= cjc_pkg::KcW'(cjc_pkg::MaxKeys))
    else $error("key count beyond store size");

  // No byte is taken from the queue while a burst plays out.
  a_no_pop_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burst_q != cjc_pkg::BParse) |-> !item_pop_o)
    else $error("queue popped during burst");

  // A status result always ends the burst and returns the parser to the map header.
  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && o_kind_d == cjc_pkg::KindStatus) |=>
      (phase_q == cjc_pkg::PhMap && burst_q == cjc_pkg::BParse && !err_q))
    else $error("status did not restart the parser");

  // A key result is read out only on a successful object.
  a_key_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_rd |-> (!err_q && phase_q == cjc_pkg::PhEnd && ek_q < kc_q))
    else $error("key read on a failed object");

endmodule

`default_nettype wire

/* sv/cbor_join_config_parser_core.sv */
// A byte is registered in the two-entry queue and parsed when the back end pops it.
// Throughput: one byte per cycle while parsing. After the final byte the burst reads
// each stored key from the key store and loads it out, checks for the end of the keys,
// passes the short and controller address steps even when absent, and loads the status;
// a failed object skips to the status. Pop stalls add to this; the queue fills, push stalls.
// Reset: asynchronous, active low; clears the parser, queue and output register
// and returns the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module cbor_join_config_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [7:0]       key_id_o,
  output logic [7:0]       key_use_o,
  output logic [63:0]      word_high_o,
  output logic [63:0]      word_low_o,
  output logic             status_o,
  output logic             last_o
);

  cjc_pkg::cfg_t  cfg_q;
  cjc_pkg::item_t item;
  logic           item_valid, item_pop, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.label_ks    <= 5'd2;
      cfg_q.label_sa    <= 5'd3;
      cfg_q.label_ca    <= 5'd4;
      cfg_q.default_use <= 8'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        cjc_pkg::RegLabelKs:    cfg_q.label_ks    <= pwdata[4:0];
        cjc_pkg::RegLabelSa:    cfg_q.label_sa    <= pwdata[4:0];
        cjc_pkg::RegLabelCa:    cfg_q.label_ca    <= pwdata[4:0];
        cjc_pkg::RegDefaultUse: cfg_q.default_use <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      cjc_pkg::RegLabelKs:    prdata = {27'd0, cfg_q.label_ks};
      cjc_pkg::RegLabelSa:    prdata = {27'd0, cfg_q.label_sa};
      cjc_pkg::RegLabelCa:    prdata = {27'd0, cfg_q.label_ca};
      cjc_pkg::RegDefaultUse: prdata = {24'd0, cfg_q.default_use};
      default:                prdata = 32'd0;
    endcase
  end

  cjc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  cjc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .kind_o       (kind_o),
    .key_id_o     (key_id_o),
    .key_use_o    (key_use_o),
    .word_high_o  (word_high_o),
    .word_low_o   (word_low_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
